// ----- rtl/core/srpg_pkg.sv -----
// Shared types, constants and helper functions of the sphere ring point generator.
package srpg_pkg;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam int          DIV_NW       = 41;
  localparam int          DIV_DW       = 10;
  localparam int          TAYLOR_TERMS = 7;
  localparam int          QDEPTH       = 2;
  localparam logic [7:0]  RING_COUNT_RST = 8'd16;
  localparam logic        REG_RING_COUNT = 1'b0;

  typedef struct packed {
    logic valid;
    logic restart;
  } q_item_t;

  typedef struct packed {
    logic busy;
    logic need_begin;
  } bk_stat_t;

  function automatic logic [7:0] sin_den(input logic [2:0] n);
    logic [7:0] d;
    unique case (n)
      3'd1:    d = 8'd6;
      3'd2:    d = 8'd20;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd72;
      3'd5:    d = 8'd110;
      3'd6:    d = 8'd156;
      3'd7:    d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cos_den(input logic [2:0] n);
    logic [7:0] d;
    unique case (n)
      3'd1:    d = 8'd2;
      3'd2:    d = 8'd12;
      3'd3:    d = 8'd30;
      3'd4:    d = 8'd56;
      3'd5:    d = 8'd90;
      3'd6:    d = 8'd132;
      3'd7:    d = 8'd182;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // Reciprocals floor(2^32 / d) of the Taylor divisors above.
  function automatic logic [31:0] sin_rcp(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd1:    m = 32'd715827882;
      3'd2:    m = 32'd214748364;
      3'd3:    m = 32'd102261126;
      3'd4:    m = 32'd59652323;
      3'd5:    m = 32'd39045157;
      3'd6:    m = 32'd27531841;
      3'd7:    m = 32'd20452225;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] cos_rcp(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd1:    m = 32'd2147483648;
      3'd2:    m = 32'd357913941;
      3'd3:    m = 32'd143165576;
      3'd4:    m = 32'd76695844;
      3'd5:    m = 32'd47721858;
      3'd6:    m = 32'd32537631;
      3'd7:    m = 32'd23598721;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > $signed({4'b0, ONE_Q30})) begin
      r = $signed(ONE_Q30);
    end else if (v < -$signed({4'b0, ONE_Q30})) begin
      r = -$signed(ONE_Q30);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/srpg_front.sv -----
// Input queue that takes request words and holds their restart flags for the back end.
module srpg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  output logic              in_ready,
  input  logic              pop,
  output srpg_pkg::q_item_t item
);
  import srpg_pkg::*;

  logic [1:0] cnt_r;
  logic       e0_r;
  logic       e1_r;
  logic       push;
  logic       take;

  assign in_ready     = (cnt_r != 2'(QDEPTH));
  assign push         = in_valid && in_ready;
  assign take         = pop && (cnt_r != 2'd0);
  assign item.valid   = (cnt_r != 2'd0);
  assign item.restart = e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      if (push && !take) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          e0_r <= in_restart;
        end else begin
          e1_r <= in_restart;
        end
      end else if (take && !push) begin
        cnt_r <= cnt_r - 2'd1;
        e0_r  <= e1_r;
      end else if (take && push) begin
        if (cnt_r == 2'd1) begin
          e0_r <= in_restart;
        end else begin
          e0_r <= e1_r;
          e1_r <= in_restart;
        end
      end
    end
  end

endmodule

// ----- rtl/core/srpg_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module srpg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [srpg_pkg::DIV_NW-1:0] dividend,
  input  logic [srpg_pkg::DIV_DW-1:0] divisor,
  output logic                        done,
  output logic [srpg_pkg::DIV_NW-1:0] quot,
  output logic [srpg_pkg::DIV_DW-1:0] rem
);
  import srpg_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, dsr_r});
  assign done  = done_r;
  assign quot  = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NW);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= DIV_DW'(trial - {1'b0, dsr_r});
        end else begin
          rem_r <= trial[DIV_DW-1:0];
        end
        quo_r <= {quo_r[DIV_NW-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/srpg_trig.sv -----
// Sequencer for sine and cosine of a fraction of a turn by Taylor sums; one divider serves both argument divisions.
module srpg_trig (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [7:0]         num,
  input  logic [8:0]         den,
  output logic               done,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);
  import srpg_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE, T_QW, T_XS, T_XW, T_X2, T_X2B, T_SM, T_CM, T_RA, T_RM, T_RQ, T_RR, T_RC, T_FIN
  } trig_state_t;

  trig_state_t        state_r;
  logic               done_r;
  logic               div_go_r;
  logic [DIV_NW-1:0]  div_a_r;
  logic [DIV_DW-1:0]  div_b_r;
  logic               div_done;
  logic [DIV_NW-1:0]  div_quot;
  logic [DIV_DW-1:0]  div_rem;
  logic [8:0]         den_r;
  logic [1:0]         quad_r;
  logic [63:0]        prod_r;
  logic [30:0]        x_r;
  logic [31:0]        x2_r;
  logic [30:0]        ts_r;
  logic [30:0]        tc_r;
  logic [2:0]         n_r;
  logic signed [35:0] sum_s_r;
  logic signed [35:0] sum_c_r;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;
  logic               sel_r;
  logic [31:0]        dvd_r;
  logic [31:0]        rcp_r;
  logic [7:0]         dsr_r;
  logic [31:0]        quo_r;
  logic [39:0]        rmd_r;
  logic [31:0]        qfix;
  logic signed [31:0] ss;
  logic signed [31:0] cs;
  logic signed [35:0] term;

  srpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // The reciprocal estimate is at most one below the true quotient.
  assign qfix  = (rmd_r >= {32'b0, dsr_r}) ? (quo_r + 32'd1) : quo_r;
  assign ss    = clamp_unit(sum_s_r);
  assign cs    = clamp_unit(sum_c_r);
  assign term  = $signed({5'b0, qfix[30:0]});
  assign done  = done_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      done_r   <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      done_r   <= 1'b0;
      div_go_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (start) begin
            den_r    <= (den == 9'd0) ? 9'd1 : den;
            div_a_r  <= DIV_NW'({num, 2'b00});
            div_b_r  <= (den == 9'd0) ? DIV_DW'(1) : DIV_DW'(den);
            div_go_r <= 1'b1;
            state_r  <= T_QW;
          end
        end
        T_QW: begin
          if (div_done) begin
            quad_r  <= div_quot[1:0];
            prod_r  <= {32'b0, PI_Q30} * {54'b0, div_rem};
            state_r <= T_XS;
          end
        end
        T_XS: begin
          div_a_r  <= prod_r[DIV_NW-1:0];
          div_b_r  <= {den_r, 1'b0};
          div_go_r <= 1'b1;
          state_r  <= T_XW;
        end
        T_XW: begin
          if (div_done) begin
            x_r     <= div_quot[30:0];
            state_r <= T_X2;
          end
        end
        T_X2: begin
          prod_r  <= {33'b0, x_r} * {33'b0, x_r};
          state_r <= T_X2B;
        end
        T_X2B: begin
          x2_r    <= prod_r[61:30];
          ts_r    <= x_r;
          tc_r    <= ONE_Q30[30:0];
          sum_s_r <= $signed({5'b0, x_r});
          sum_c_r <= $signed({4'b0, ONE_Q30});
          n_r     <= 3'd1;
          state_r <= T_SM;
        end
        T_SM: begin
          prod_r  <= {33'b0, ts_r} * {32'b0, x2_r};
          sel_r   <= 1'b0;
          state_r <= T_RA;
        end
        T_CM: begin
          prod_r  <= {33'b0, tc_r} * {32'b0, x2_r};
          sel_r   <= 1'b1;
          state_r <= T_RA;
        end
        T_RA: begin
          dvd_r   <= prod_r[61:30];
          rcp_r   <= sel_r ? cos_rcp(n_r) : sin_rcp(n_r);
          dsr_r   <= sel_r ? cos_den(n_r) : sin_den(n_r);
          state_r <= T_RM;
        end
        T_RM: begin
          prod_r  <= {32'b0, dvd_r} * {32'b0, rcp_r};
          state_r <= T_RQ;
        end
        T_RQ: begin
          quo_r   <= prod_r[63:32];
          state_r <= T_RR;
        end
        T_RR: begin
          rmd_r   <= {8'b0, dvd_r} - ({8'b0, quo_r} * {32'b0, dsr_r});
          state_r <= T_RC;
        end
        T_RC: begin
          if (!sel_r) begin
            ts_r    <= qfix[30:0];
            sum_s_r <= n_r[0] ? (sum_s_r - term) : (sum_s_r + term);
            state_r <= T_CM;
          end else begin
            tc_r    <= qfix[30:0];
            sum_c_r <= n_r[0] ? (sum_c_r - term) : (sum_c_r + term);
            if (n_r == 3'(TAYLOR_TERMS)) begin
              state_r <= T_FIN;
            end else begin
              n_r     <= n_r + 3'd1;
              state_r <= T_SM;
            end
          end
        end
        T_FIN: begin
          unique case (quad_r)
            2'd0: begin sin_r <= ss;  cos_r <= cs;  end
            2'd1: begin sin_r <= cs;  cos_r <= -ss; end
            2'd2: begin sin_r <= -ss; cos_r <= -cs; end
            2'd3: begin sin_r <= -cs; cos_r <= ss;  end
          endcase
          done_r  <= 1'b1;
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/srpg_back.sv -----
// Back end that walks the rings, evaluates each point and holds the result word.
module srpg_back #(
  parameter int MAX_RINGS       = 128,
  parameter int COORD_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         ring_count,
  input  logic               cfg_wr,
  input  srpg_pkg::q_item_t  item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        pos_x,
  output logic [15:0]        pos_y,
  output logic [15:0]        pos_z,
  output logic               last_point,
  output srpg_pkg::bk_stat_t stat
);
  import srpg_pkg::*;

  localparam int SH = 60 - COORD_FRAC_BITS;

  typedef enum logic [3:0] {
    B_IDLE, B_LDGO, B_LDW, B_LDC, B_PTGO, B_PTW, B_RX, B_RY, B_ADV, B_FIN
  } back_state_t;

  back_state_t        state_r;
  logic               need_begin_r;
  logic               ld_adv_r;
  logic               last_r;
  logic signed [8:0]  ring_r;
  logic [7:0]         point_r;
  logic [7:0]         points_r;
  logic signed [31:0] sine_r;
  logic signed [31:0] cosine_r;
  logic signed [31:0] ld_s_r;
  logic signed [31:0] ld_c_r;
  logic signed [31:0] ct_r;
  logic signed [63:0] prod_r;
  logic [38:0]        cntp_r;
  logic [15:0]        res_x_r;
  logic [15:0]        res_y_r;
  logic [15:0]        res_z_r;
  logic               trig_go_r;
  logic [7:0]         trig_num_r;
  logic [8:0]         trig_den_r;
  logic               trig_done;
  logic signed [31:0] trig_sin;
  logic signed [31:0] trig_cos;
  logic               out_valid_r;
  logic [15:0]        pos_x_r;
  logic [15:0]        pos_y_r;
  logic [15:0]        pos_z_r;
  logic               last_point_r;
  logic [7:0]         rc_eff;
  logic [6:0]         half;
  logic signed [8:0]  half_s;
  logic [8:0]         cnt;
  logic               fin_load;
  logic               nb_set;
  logic               nb_clr;

  function automatic logic [15:0] to_coord(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] rnd;
    logic [15:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    rnd = (mag + (64'd1 << (SH - 1))) >> SH;
    if (!v[63]) begin
      r = (rnd > 64'd32767) ? 16'h7fff : rnd[15:0];
    end else begin
      r = (rnd > 64'd32768) ? 16'h8000 : 16'(16'd0 - rnd[15:0]);
    end
    return r;
  endfunction

  srpg_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_go_r),
    .num   (trig_num_r),
    .den   (trig_den_r),
    .done  (trig_done),
    .sin_q (trig_sin),
    .cos_q (trig_cos)
  );

  assign rc_eff = (ring_count < 8'd2) ? 8'd2 :
                  (ring_count > 8'(MAX_RINGS)) ? 8'(MAX_RINGS) : ring_count;
  assign half   = rc_eff[7:1];
  assign half_s = $signed({2'b0, half});
  assign cnt    = cntp_r[38:30];

  assign fin_load = (state_r == B_FIN) && (!out_valid_r || out_ready);
  assign nb_clr   = (state_r == B_IDLE) && item.valid &&
                    (item.restart || need_begin_r || (points_r == 8'd0));
  assign nb_set   = (state_r == B_LDGO) && (ring_r > half_s) && ld_adv_r;

  assign pop             = (state_r == B_IDLE) && item.valid;
  assign out_valid       = out_valid_r;
  assign pos_x           = pos_x_r;
  assign pos_y           = pos_y_r;
  assign pos_z           = pos_z_r;
  assign last_point      = last_point_r;
  assign stat.busy       = (state_r != B_IDLE);
  assign stat.need_begin = need_begin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      need_begin_r <= 1'b1;
      points_r     <= 8'd0;
      trig_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      trig_go_r <= 1'b0;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (item.valid) begin
            last_r <= 1'b0;
            if (nb_clr) begin
              ring_r       <= -half_s;
              point_r      <= 8'd0;
              points_r     <= 8'd0;
              sine_r       <= '0;
              cosine_r     <= '0;
              ld_adv_r     <= 1'b0;
              state_r      <= B_LDGO;
            end else begin
              state_r <= B_PTGO;
            end
          end
        end
        B_LDGO: begin
          if (ring_r > half_s) begin
            if (ld_adv_r) begin
              last_r       <= 1'b1;
              state_r      <= B_FIN;
            end else begin
              ring_r   <= -half_s;
              points_r <= 8'd0;
              state_r  <= B_PTGO;
            end
          end else begin
            trig_num_r <= 8'(ring_r + half_s);
            trig_den_r <= {half, 2'b00};
            trig_go_r  <= 1'b1;
            state_r    <= B_LDW;
          end
        end
        B_LDW: begin
          if (trig_done) begin
            ld_s_r <= trig_sin;
            ld_c_r <= trig_cos;
            cntp_r <= trig_sin[31] ? 39'd0 :
                      ({31'b0, half, 1'b1} * {8'b0, trig_sin[30:0]});
            state_r <= B_LDC;
          end
        end
        B_LDC: begin
          if (cnt != 9'd0) begin
            sine_r   <= ld_s_r;
            cosine_r <= ld_c_r;
            points_r <= cnt[8] ? 8'd255 : cnt[7:0];
            point_r  <= 8'd0;
            state_r  <= ld_adv_r ? B_FIN : B_PTGO;
          end else begin
            ring_r  <= ring_r + 9'sd1;
            state_r <= B_LDGO;
          end
        end
        B_PTGO: begin
          trig_num_r <= point_r;
          trig_den_r <= {1'b0, points_r};
          trig_go_r  <= 1'b1;
          state_r    <= B_PTW;
        end
        B_PTW: begin
          if (trig_done) begin
            prod_r  <= trig_sin * sine_r;
            ct_r    <= trig_cos;
            state_r <= B_RX;
          end
        end
        B_RX: begin
          res_x_r <= to_coord(prod_r);
          prod_r  <= ct_r * sine_r;
          state_r <= B_RY;
        end
        B_RY: begin
          res_y_r <= to_coord(prod_r);
          res_z_r <= to_coord($signed({{2{cosine_r[31]}}, cosine_r, 30'b0}));
          point_r <= point_r + 8'd1;
          state_r <= B_ADV;
        end
        B_ADV: begin
          if (point_r >= points_r) begin
            ring_r   <= ring_r + 9'sd1;
            ld_adv_r <= 1'b1;
            state_r  <= B_LDGO;
          end else begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          if (fin_load) begin
            pos_x_r      <= res_x_r;
            pos_y_r      <= res_y_r;
            pos_z_r      <= res_z_r;
            last_point_r <= last_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
      if (cfg_wr || nb_set) begin
        need_begin_r <= 1'b1;
      end else if (nb_clr) begin
        need_begin_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/sphere_ring_point_generator_core.sv -----
// Top level of the sphere ring point generator: register port, input queue and back end.
//
//   channel  | direction | handshake                    | word
//   in_      | slave     | in_tvalid / in_tready        | restart flag
//   out_     | master    | out_tvalid / out_tready      | pos_x, pos_y, pos_z, last_point
//   cfg_     | slave     | psel, penable, pwrite, pready| ring_count at byte address 0
//
// Each sine/cosine evaluation makes two runs of the one-bit-per-cycle divider and
// sums seven Taylor terms. A point takes one such evaluation, plus one more for
// every ring loaded when its ring ends or a pass begins. Reset is synchronous and
// active low; after reset the first request starts a pass. A two-word input queue
// and the output register let either side stall without stopping the other.
module sphere_ring_point_generator_core #(
  parameter int MAX_RINGS       = 128,
  parameter int COORD_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import srpg_pkg::*;

  logic       [7:0] ring_count_r;
  logic             cfg_wr;
  logic             pop;
  q_item_t          item;
  bk_stat_t         bk_stat;
  logic      [15:0] pos_x;
  logic      [15:0] pos_y;
  logic      [15:0] pos_z;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_RING_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_RING_COUNT) ? {24'b0, ring_count_r} : 32'd0;
  assign out_tdata  = {pos_z, pos_y, pos_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= RING_COUNT_RST;
    end else if (cfg_wr) begin
      ring_count_r <= cfg_pwdata[7:0];
    end
  end

  srpg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .pop        (pop),
    .item       (item)
  );

  srpg_back #(
    .MAX_RINGS       (MAX_RINGS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_count (ring_count_r),
    .cfg_wr     (cfg_wr),
    .item       (item),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .last_point (out_tlast),
    .stat       (bk_stat)
  );

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (ring_count_r == $past(cfg_pwdata[7:0])))
    else $error("ring_count register did not take the written word");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> bk_stat.need_begin)
    else $error("register write did not schedule a new pass");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bk_stat.busy))
    else $error("result word appeared without a word in progress");

endmodule
